>>> hdl/pls_pkg.sv
`default_nettype none

package pls_pkg;

	// fixed field widths of the command and result words
	localparam int CMD_W   = 3;
	localparam int POS_W   = 7;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 7;
	localparam int STAT_W  = 2;

	// command codes
	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_INSERT_AT  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_REMOVE_AT  = 3'd5;
	localparam logic [CMD_W-1:0] CMD_READ_AT    = 3'd6;
	localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd7;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]          cmd;
		logic [POS_W-1:0]          position;
		logic signed [VALUE_W-1:0] item_value;
	} pls_cmd_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] read_value;
		logic signed [VALUE_W-1:0] front_value;
		logic signed [VALUE_W-1:0] back_value;
		logic [COUNT_W-1:0]        element_count;
		logic                      is_empty;
		logic [STAT_W-1:0]         status;
	} pls_result_t;

endpackage

`default_nettype wire

>>> hdl/positional_list_store.sv
`default_nettype none

// Bounded deque of signed 32-bit values in a circular single-port store.
// Command channel: a word on 'command' is taken at a rising edge where start
// is high and busy is low. Commands: push/pop at either end, insert, remove
// or read at a position, and clear. Bad requests leave the list untouched
// and are reported in the status field.
// Result channel: one word per command on 'result', valid for exactly one
// cycle while done is high. The receiver cannot hold it off.
// Sequence: push, pop, read, clear and rejected commands pass through the
// exec, front, back and done states. Insert and remove also pass a shift read
// and a shift write state for each element moved, and insert ends with a
// final write state. Elements are moved one at a time through the single
// memory port (read, then write). busy drops in the cycle that done is
// raised, so the next command may be taken in that cycle.
// Reset: asynchronous, active low; the list comes up empty with head at slot
// zero. Store contents are not cleared; only written entries reach the result.
module positional_list_store
	import pls_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire pls_cmd_t    command,
	output logic             done,
	output pls_result_t      result
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > POS_W) ? ((CW > COUNT_W) ? CW : COUNT_W) :
		((POS_W > COUNT_W) ? POS_W : COUNT_W);

	// sequencer states
	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_EXEC     = 3'd1;
	localparam logic [2:0] S_SHIFT_RD = 3'd2;
	localparam logic [2:0] S_SHIFT_WR = 3'd3;
	localparam logic [2:0] S_INS_WR   = 3'd4;
	localparam logic [2:0] S_FRONT    = 3'd5;
	localparam logic [2:0] S_BACK     = 3'd6;
	localparam logic [2:0] S_DONE     = 3'd7;

	logic [2:0]         state_q;
	logic [AW-1:0]      head_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      idx_q;
	logic [CMD_W-1:0]   cmd_q;
	logic [POS_W-1:0]   pos_q;
	logic [VALUE_W-1:0] val_q;
	logic [STAT_W-1:0]  status_q;
	logic               rd_ok_q;
	logic [VALUE_W-1:0] read_q;
	logic [VALUE_W-1:0] front_q;
	logic               done_q;
	pls_result_t        result_q;

	logic [VALUE_W-1:0] element_store_q [DEPTH];
	logic [VALUE_W-1:0] rdata_q;

	logic               mem_we;
	logic [AW-1:0]      mem_addr;
	logic [VALUE_W-1:0] mem_wdata;

	logic [XW-1:0]      pos_x;
	logic [XW-1:0]      cnt_x;
	logic [CW-1:0]      pos_c;
	logic [CW-1:0]      pos_inc;
	logic [CW-1:0]      idx_inc;
	logic [CW-1:0]      idx_dec;
	logic [AW-1:0]      head_dec;
	logic               full;
	logic               empty;
	logic [STAT_W-1:0]  status_d;
	logic               ok;

	// physical slot of list position i, wrapping at DEPTH
	function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] i);
		logic [CW:0] s;
		s = (CW+1)'(h) + (CW+1)'(i);
		if (s >= (CW+1)'(DEPTH))
			s = s - (CW+1)'(DEPTH);
		return s[AW-1:0];
	endfunction

	assign pos_x    = XW'(pos_q);
	assign cnt_x    = XW'(count_q);
	assign pos_c    = pos_x[CW-1:0];
	assign pos_inc  = pos_c + 1'b1;
	assign idx_inc  = idx_q + 1'b1;
	assign idx_dec  = idx_q - 1'b1;
	assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - 1'b1;
	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);

	// request checks on the latched command
	always_comb begin
		status_d = ST_OK;
		case (cmd_q)
			CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
				if (full)
					status_d = ST_FULL;
			end
			CMD_POP_FRONT, CMD_POP_BACK: begin
				if (empty)
					status_d = ST_EMPTY;
			end
			CMD_INSERT_AT: begin
				if (full)
					status_d = ST_FULL;
				else if (pos_x > cnt_x)
					status_d = ST_RANGE;
			end
			CMD_REMOVE_AT, CMD_READ_AT: begin
				if (empty)
					status_d = ST_EMPTY;
				else if (pos_x >= cnt_x)
					status_d = ST_RANGE;
			end
			default: status_d = ST_OK;
		endcase
	end

	assign ok = (status_d == ST_OK);

	// single memory port: one read or one write per cycle
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = head_q;
		mem_wdata = val_q;
		case (state_q)
			S_EXEC: begin
				if (ok) begin
					case (cmd_q)
						CMD_PUSH_FRONT: begin
							mem_we   = 1'b1;
							mem_addr = head_dec;
						end
						CMD_PUSH_BACK: begin
							mem_we   = 1'b1;
							mem_addr = slot(head_q, count_q);
						end
						CMD_READ_AT: mem_addr = slot(head_q, pos_c);
						default: mem_addr = head_q;
					endcase
				end
			end
			S_SHIFT_RD: begin
				if (cmd_q == CMD_INSERT_AT)
					mem_addr = slot(head_q, idx_dec);
				else
					mem_addr = slot(head_q, idx_inc);
			end
			S_SHIFT_WR: begin
				mem_we    = 1'b1;
				mem_addr  = slot(head_q, idx_q);
				mem_wdata = rdata_q;
			end
			S_INS_WR: begin
				mem_we   = 1'b1;
				mem_addr = slot(head_q, pos_c);
			end
			S_FRONT: mem_addr = head_q;
			S_BACK:  mem_addr = slot(head_q, count_q - 1'b1);
			default: mem_addr = head_q;
		endcase
	end

	// element store with a registered read port
	always_ff @(posedge clk) begin
		if (mem_we)
			element_store_q[mem_addr] <= mem_wdata;
		else
			rdata_q <= element_store_q[mem_addr];
	end

	// command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			count_q  <= '0;
			idx_q    <= '0;
			cmd_q    <= CMD_PUSH_FRONT;
			pos_q    <= '0;
			val_q    <= '0;
			status_q <= ST_OK;
			rd_ok_q  <= 1'b0;
			read_q   <= '0;
			front_q  <= '0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q   <= command.cmd;
						pos_q   <= command.position;
						val_q   <= command.item_value;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					status_q <= status_d;
					rd_ok_q  <= ok && (cmd_q == CMD_READ_AT);
					state_q  <= S_FRONT;
					if (ok) begin
						case (cmd_q)
							CMD_PUSH_FRONT: begin
								head_q  <= head_dec;
								count_q <= count_q + 1'b1;
							end
							CMD_PUSH_BACK: count_q <= count_q + 1'b1;
							CMD_POP_FRONT: begin
								head_q  <= slot(head_q, CW'(1));
								count_q <= count_q - 1'b1;
							end
							CMD_POP_BACK: count_q <= count_q - 1'b1;
							CMD_INSERT_AT: begin
								idx_q   <= count_q;
								state_q <= (pos_c == count_q) ? S_INS_WR : S_SHIFT_RD;
							end
							CMD_REMOVE_AT: begin
								count_q <= count_q - 1'b1;
								idx_q   <= pos_c;
								state_q <= (pos_inc == count_q) ? S_FRONT : S_SHIFT_RD;
							end
							CMD_CLEAR: begin
								head_q  <= '0;
								count_q <= '0;
							end
							default: state_q <= S_FRONT;
						endcase
					end
				end
				S_SHIFT_RD: state_q <= S_SHIFT_WR;
				S_SHIFT_WR: begin
					// one element moved; step towards the opening or the gap
					if (cmd_q == CMD_INSERT_AT) begin
						idx_q   <= idx_dec;
						state_q <= (idx_dec == pos_c) ? S_INS_WR : S_SHIFT_RD;
					end else begin
						idx_q   <= idx_inc;
						state_q <= (idx_inc == count_q) ? S_FRONT : S_SHIFT_RD;
					end
				end
				S_INS_WR: begin
					count_q <= count_q + 1'b1;
					state_q <= S_FRONT;
				end
				S_FRONT: begin
					read_q  <= rd_ok_q ? rdata_q : '0;
					state_q <= S_BACK;
				end
				S_BACK: begin
					front_q <= rdata_q;
					state_q <= S_DONE;
				end
				S_DONE: begin
					// build the result word from the final list state
					result_q.read_value    <= read_q;
					result_q.front_value   <= empty ? '0 : front_q;
					result_q.back_value    <= empty ? '0 : rdata_q;
					result_q.element_count <= cnt_x[COUNT_W-1:0];
					result_q.is_empty      <= empty;
					result_q.status        <= status_q;
					done_q                 <= 1'b1;
					state_q                <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTHESIS
	a_done_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q) == S_DONE)
		else $error("result strobe without a finished command");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("element count beyond capacity");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> result_q.is_empty == (count_q == '0))
		else $error("empty flag disagrees with count");

	a_no_write_on_readout: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FRONT || state_q == S_BACK || state_q == S_DONE) |-> !mem_we)
		else $error("store written during result readout");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && result_q.status == ST_FULL) |-> count_q == CW'(DEPTH))
		else $error("full status while list has room");
`endif

endmodule

`default_nettype wire

>>> test/positional_list_store_tb.sv
`default_nettype none

module positional_list_store_tb;
	import pls_pkg::*;

	localparam int LIST_DEPTH = 64;
	// slowest command: every element shifted, plus the fixed handshake cycles
	localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 16;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	pls_cmd_t    command = '0;
	logic        busy;
	logic        done;
	pls_result_t result;

	positional_list_store #(
		.DEPTH(LIST_DEPTH)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.command(command),
		.done   (done),
		.result (result)
	);

	// shadow of the list, updated as each word is taken
	logic signed [VALUE_W-1:0] list_slots [LIST_DEPTH];
	logic [5:0]                list_head = '0;
	int                        list_len = 0;

	pls_cmd_t    commands_to_issue [$];
	pls_result_t list_views_due [$];
	pls_result_t next_view;
	int          words_queued = 0;
	int          words_taken = 0;
	int          idle_left = 0;
	int          calm_left = 0;
	int          failures = 0;
	int          gen_len = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#80_000_000;
		$display("positional_list_store test failed");
		$finish;
	end

	function automatic logic [5:0] slot_of(int idx);
		return 6'(int'(list_head) + idx);
	endfunction

	// apply one command to the shadow list and form the word the block should return
	function automatic void apply_list_command(input pls_cmd_t c, output pls_result_t r);
		int                        k;
		int                        pos;
		logic [STAT_W-1:0]         st;
		logic signed [VALUE_W-1:0] rd;
		pos = int'(c.position);
		st  = ST_OK;
		rd  = '0;
		case (c.cmd)
			CMD_PUSH_FRONT: begin
				if (list_len >= LIST_DEPTH) st = ST_FULL;
				else begin
					list_head = list_head - 6'd1;
					list_slots[list_head] = c.item_value;
					list_len++;
				end
			end
			CMD_PUSH_BACK: begin
				if (list_len >= LIST_DEPTH) st = ST_FULL;
				else begin
					list_slots[slot_of(list_len)] = c.item_value;
					list_len++;
				end
			end
			CMD_POP_FRONT: begin
				if (list_len == 0) st = ST_EMPTY;
				else begin
					list_head = slot_of(1);
					list_len--;
				end
			end
			CMD_POP_BACK: begin
				if (list_len == 0) st = ST_EMPTY;
				else list_len--;
			end
			CMD_INSERT_AT: begin
				// full is reported ahead of a bad position
				if (list_len >= LIST_DEPTH) st = ST_FULL;
				else if (pos > list_len) st = ST_RANGE;
				else begin
					for (k = list_len; k > pos; k--)
						list_slots[slot_of(k)] = list_slots[slot_of(k - 1)];
					list_slots[slot_of(pos)] = c.item_value;
					list_len++;
				end
			end
			CMD_REMOVE_AT: begin
				if (list_len == 0) st = ST_EMPTY;
				else if (pos >= list_len) st = ST_RANGE;
				else begin
					for (k = pos; k + 1 < list_len; k++)
						list_slots[slot_of(k)] = list_slots[slot_of(k + 1)];
					list_len--;
				end
			end
			CMD_READ_AT: begin
				if (list_len == 0) st = ST_EMPTY;
				else if (pos >= list_len) st = ST_RANGE;
				else rd = list_slots[slot_of(pos)];
			end
			default: begin
				list_head = '0;
				list_len  = 0;
			end
		endcase
		r.read_value    = rd;
		r.front_value   = (list_len != 0) ? list_slots[slot_of(0)] : '0;
		r.back_value    = (list_len != 0) ? list_slots[slot_of(list_len - 1)] : '0;
		r.element_count = COUNT_W'(list_len);
		r.is_empty      = (list_len == 0);
		r.status        = st;
	endfunction

	function automatic pls_cmd_t random_word();
		pls_cmd_t w;
		w.cmd        = CMD_W'($urandom_range(0, 7));
		w.position   = POS_W'($urandom_range(0, 127));
		w.item_value = $urandom;
		return w;
	endfunction

	// values lean towards the extremes
	function automatic logic signed [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return '0;
			3: return -32'sd1;
			4: return $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	// idle cycles after a word: mostly none or short, now and then long,
	// with occasional runs of back-to-back words
	function automatic int pick_idle();
		int r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 49) == 0) begin
			calm_left = $urandom_range(20, 100);
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		else if (r < 90) return $urandom_range(1, 4);
		else if (r < 97) return $urandom_range(5, 20);
		else return $urandom_range(50, 300);
	endfunction

	// queue a word; the generator keeps a running length so positions can aim in range
	task automatic add_word(logic [CMD_W-1:0] c, int pos, logic signed [VALUE_W-1:0] v);
		pls_cmd_t w;
		w.cmd        = c;
		w.position   = POS_W'(pos);
		w.item_value = v;
		commands_to_issue.push_back(w);
		words_queued++;
		case (c)
			CMD_PUSH_FRONT, CMD_PUSH_BACK: if (gen_len < LIST_DEPTH) gen_len++;
			CMD_POP_FRONT, CMD_POP_BACK: if (gen_len > 0) gen_len--;
			CMD_INSERT_AT: if (gen_len < LIST_DEPTH && pos <= gen_len) gen_len++;
			CMD_REMOVE_AT: if (gen_len > 0 && pos < gen_len) gen_len--;
			CMD_READ_AT: ;
			default: gen_len = 0;
		endcase
	endtask

	function automatic int in_range_pos(bit for_insert);
		int hi;
		if ($urandom_range(0, 99) < 15) return $urandom_range(0, 127);
		hi = for_insert ? gen_len : gen_len - 1;
		return (hi > 0) ? $urandom_range(0, hi) : 0;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			failures++;
		end
	endtask

	// driver: present the next word, hold it while busy, idle between words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start     <= 1'b0;
			command   <= '0;
			idle_left = 0;
		end else if (!(start && busy)) begin
			if (start) begin
				apply_list_command(command, next_view);
				list_views_due.push_back(next_view);
				words_taken++;
			end
			if (idle_left > 0) begin
				idle_left--;
				start   <= 1'b0;
				command <= random_word();
			end else if (commands_to_issue.size() > 0) begin
				command   <= commands_to_issue.pop_front();
				start     <= 1'b1;
				idle_left = pick_idle();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: every strobed result word against the oldest outstanding view
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (list_views_due.size() == 0) begin
				$error("result word with nothing outstanding");
				failures++;
			end else begin
				pls_result_t due;
				due = list_views_due.pop_front();
				check_field("read_value", due.read_value, result.read_value);
				check_field("front_value", due.front_value, result.front_value);
				check_field("back_value", due.back_value, result.back_value);
				check_field("element_count", 32'(due.element_count), 32'(result.element_count));
				check_field("is_empty", 32'(due.is_empty), 32'(result.is_empty));
				check_field("status", 32'(due.status), 32'(result.status));
			end
		end
	end

	initial begin
		int kind;
		int n;
		int i;
		int r;
		logic [CMD_W-1:0] c;

		// directed: empty-list requests, extremes, boundary positions, clear
		add_word(CMD_POP_FRONT, 0, 32'sd0);
		add_word(CMD_POP_BACK, 127, -32'sd1);
		add_word(CMD_REMOVE_AT, 0, 32'sd0);
		add_word(CMD_READ_AT, 0, 32'sd0);
		add_word(CMD_PUSH_BACK, 127, 32'sh7FFF_FFFF);
		add_word(CMD_PUSH_FRONT, 0, 32'sh8000_0000);
		add_word(CMD_INSERT_AT, 1, -32'sd1);
		add_word(CMD_INSERT_AT, 3, 32'sd0);
		add_word(CMD_INSERT_AT, 5, 32'sd12345);
		add_word(CMD_READ_AT, 0, 32'sd0);
		add_word(CMD_READ_AT, 3, 32'sd0);
		add_word(CMD_READ_AT, 4, 32'sd0);
		add_word(CMD_READ_AT, 127, 32'sd0);
		add_word(CMD_REMOVE_AT, 4, 32'sd0);
		add_word(CMD_REMOVE_AT, 1, 32'sd0);
		add_word(CMD_REMOVE_AT, 0, 32'sd0);
		add_word(CMD_POP_BACK, 0, 32'sd0);
		add_word(CMD_POP_FRONT, 0, 32'sd0);
		add_word(CMD_INSERT_AT, 0, 32'sd5);
		add_word(CMD_INSERT_AT, 1, -32'sd5);
		add_word(CMD_CLEAR, 0, 32'sd0);
		add_word(CMD_CLEAR, 127, -32'sd1);
		add_word(CMD_REMOVE_AT, 127, 32'sd0);
		add_word(CMD_PUSH_FRONT, 64, 32'sd1);

		// random: fill runs (reaching full), drain runs, mixed traffic and noise
		while (words_queued < 1800) begin
			kind = $urandom_range(0, 9);
			if (kind <= 2) begin
				n = $urandom_range(8, 80);
				for (i = 0; i < n; i++) begin
					r = $urandom_range(0, 2);
					if (r == 0) add_word(CMD_PUSH_FRONT, $urandom_range(0, 127), pick_value());
					else if (r == 1) add_word(CMD_PUSH_BACK, $urandom_range(0, 127), pick_value());
					else add_word(CMD_INSERT_AT, in_range_pos(1'b1), pick_value());
				end
			end else if (kind <= 4) begin
				n = $urandom_range(8, 80);
				for (i = 0; i < n; i++) begin
					r = $urandom_range(0, 3);
					if (r == 0) add_word(CMD_POP_FRONT, $urandom_range(0, 127), pick_value());
					else if (r == 1) add_word(CMD_POP_BACK, $urandom_range(0, 127), pick_value());
					else if (r == 2) add_word(CMD_REMOVE_AT, in_range_pos(1'b0), pick_value());
					else add_word(CMD_READ_AT, in_range_pos(1'b0), pick_value());
				end
			end else if (kind <= 8) begin
				n = $urandom_range(5, 40);
				for (i = 0; i < n; i++) begin
					r = $urandom_range(0, 99);
					if (r < 25) c = CMD_READ_AT;
					else if (r < 40) c = CMD_INSERT_AT;
					else if (r < 55) c = CMD_REMOVE_AT;
					else if (r < 67) c = CMD_PUSH_FRONT;
					else if (r < 79) c = CMD_PUSH_BACK;
					else if (r < 88) c = CMD_POP_FRONT;
					else if (r < 98) c = CMD_POP_BACK;
					else c = CMD_CLEAR;
					if (c == CMD_INSERT_AT) add_word(c, in_range_pos(1'b1), pick_value());
					else if (c == CMD_REMOVE_AT || c == CMD_READ_AT)
						add_word(c, in_range_pos(1'b0), pick_value());
					else add_word(c, $urandom_range(0, 127), pick_value());
				end
			end else begin
				n = $urandom_range(1, 6);
				for (i = 0; i < n; i++) begin
					pls_cmd_t w;
					w = random_word();
					add_word(w.cmd, int'(w.position), w.item_value);
				end
				if ($urandom_range(0, 1) == 1)
					add_word(CMD_CLEAR, $urandom_range(0, 127), pick_value());
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (words_taken < words_queued || list_views_due.size() != 0)
			@(posedge clk);
		// catch any stray result words after the last one due
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (failures == 0) begin
			$display("positional_list_store test passed");
		end else begin
			$display("positional_list_store test failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
